// ===== src/sfr_pkg.sv =====
// shared types, constants and helpers for the stream find-and-replace block
`default_nettype none
package sfr_pkg;

  // window and string limits
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int WIN_W           = $clog2(MAX_PATTERN);
  localparam int LEN_W           = 4;
  localparam int BURST_W         = 3;

  // output queue depth in bursts
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // input word kinds
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // register map, one 64-bit register every 8 bytes
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_idx_t;

  // broadcast control for the window cells
  typedef struct packed {
    logic       load;
    logic       shift;
    logic [7:0] new_byte;
  } cell_ctl_t;

  // up to eight output bytes, first byte in the low lane
  typedef struct packed {
    logic [63:0]        bytes;
    logic [BURST_W-1:0] len_m1;
  } burst_t;

  // zero counts as one, anything above max saturates
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] max);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > max) begin
      r = max;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/stream_find_and_replace.sv =====
// top level: registers, line control, window row and output queue
//
// Streaming find-and-replace on text, one byte word per input handshake.
// Input channel: in_valid/in_stall with in_req_type (0 data, 1 end of input)
// and in_data_byte. Result channel: out_valid/out_stall with out_byte and
// out_last_of_run, which marks the last byte caused by one input word.
// An input word is taken every cycle as long as the four-entry burst queue
// has room; each word that produces output queues one burst of 1 to 8 bytes
// (a held byte, the replacement, or the pending bytes plus a newline).
// The serializer sends one byte per cycle while out_stall is low, so input
// runs at one word per cycle while each word yields at most one byte, and
// slows to the output byte rate when replacements or flushes are longer.
// The first byte of a result passes the burst queue, then the serializer register.
// Reset (rst_n low, synchronous) empties the window, the queue and the
// serializer and loads pattern 0/length 1, replacement 0/length 1.
// A stalled receiver holds the current byte; once the queue fills, in_stall
// rises. Registers sit on an APB port at 8-byte steps; writing the pattern
// length drops pending window bytes. Write registers only while idle.
`default_nettype none
module stream_find_and_replace import sfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0]      pattern_bytes_r;
  logic [LEN_W-1:0] pattern_length_r;
  logic [63:0]      replacement_bytes_r;
  logic [LEN_W-1:0] replacement_length_r;
  logic [WIN_W-1:0] count_r, count_nxt;
  logic             line_open_r, line_open_nxt;
  logic [LEN_W-1:0] plen, rlen;
  reg_idx_t         reg_sel;
  logic             cfg_wr;
  logic             accept;
  logic             is_end, is_nl, is_data;
  logic             full_win;
  logic             hit;
  logic [7:0]       head;
  logic [63:0]      flush_bytes;
  cell_ctl_t        ctl;
  logic             push;
  burst_t           burst;
  logic             q_full;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  assign plen = clamp_len(pattern_length_r, LEN_W'(MAX_PATTERN));
  assign rlen = clamp_len(replacement_length_r, LEN_W'(MAX_REPLACEMENT));

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BYTES:      prdata = pattern_bytes_r;
      REG_PATTERN_LENGTH:     prdata = {60'd0, pattern_length_r};
      REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_r;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, replacement_length_r};
      default:                prdata = '0;
    endcase
  end

  // input word decode
  assign accept   = in_valid & ~in_stall;
  assign in_stall = q_full;
  assign is_end   = (in_req_type == REQ_END);
  assign is_nl    = (in_req_type == REQ_DATA) & (in_data_byte == NEWLINE_BYTE);
  assign is_data  = (in_req_type == REQ_DATA) & ~is_nl;
  assign full_win = ({1'b0, count_r} + LEN_W'(1)) == plen;

  assign ctl.load     = accept & is_data;
  assign ctl.shift    = full_win & ~hit;
  assign ctl.new_byte = in_data_byte;

  sfr_window u_window (
    .clk         (clk),
    .ctl         (ctl),
    .count       (count_r),
    .plen        (plen),
    .pattern     (pattern_bytes_r),
    .hit         (hit),
    .head        (head),
    .flush_bytes (flush_bytes)
  );

  // burst selection and window bookkeeping
  always_comb begin
    push          = 1'b0;
    burst.bytes   = flush_bytes;
    burst.len_m1  = count_r;
    count_nxt     = count_r;
    line_open_nxt = line_open_r;
    if (accept) begin
      if (is_nl || (is_end && line_open_r)) begin
        push          = 1'b1;
        count_nxt     = '0;
        line_open_nxt = 1'b0;
      end else if (is_data) begin
        line_open_nxt = 1'b1;
        if (!full_win) begin
          count_nxt = count_r + WIN_W'(1);
        end else if (hit) begin
          push         = 1'b1;
          burst.bytes  = replacement_bytes_r;
          burst.len_m1 = BURST_W'(rlen - LEN_W'(1));
          count_nxt    = '0;
        end else begin
          push         = 1'b1;
          burst.bytes  = {56'd0, head};
          burst.len_m1 = '0;
        end
      end
    end
    // a new pattern length drops pending bytes
    if (cfg_wr && reg_sel == REG_PATTERN_LENGTH) begin
      count_nxt = '0;
    end
  end

  sfr_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (burst),
    .full       (q_full),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_last   (out_last_of_run),
    .out_stall  (out_stall)
  );

  // configuration and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r      <= '0;
      pattern_length_r     <= LEN_W'(1);
      replacement_bytes_r  <= '0;
      replacement_length_r <= LEN_W'(1);
      count_r              <= '0;
      line_open_r          <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      line_open_r <= line_open_nxt;
      if (cfg_wr) begin
        case (reg_sel)
          REG_PATTERN_BYTES:      pattern_bytes_r      <= pwdata;
          REG_PATTERN_LENGTH:     pattern_length_r     <= pwdata[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  replacement_bytes_r  <= pwdata;
          REG_REPLACEMENT_LENGTH: replacement_length_r <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sfr_cell.sv =====
// one window cell: holds a pending byte and compares it with its pattern lane
`default_nettype none
module sfr_cell import sfr_pkg::*; (
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire logic       tail_sel,
  input  wire logic [7:0] next_eff,
  input  wire logic [7:0] pat_byte,
  output logic [7:0]      stored_o,
  output logic [7:0]      eff_o,
  output logic            match_o
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // the tail cell sees the incoming byte in place of its stored one
  assign eff_o    = tail_sel ? ctl.new_byte : byte_r;
  assign stored_o = byte_r;
  assign match_o  = (eff_o == pat_byte);

  // on a miss the row moves one place toward the head
  assign byte_nxt = ctl.shift ? next_eff : eff_o;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_r <= byte_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfr_window.sv =====
// row of window cells with the pattern compare and flush word
`default_nettype none
module sfr_window import sfr_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WIN_W-1:0]  count,
  input  wire logic [LEN_W-1:0]  plen,
  input  wire logic [63:0]       pattern,
  output logic                   hit,
  output logic [7:0]             head,
  output logic [63:0]            flush_bytes
);

  logic [7:0]             stored [MAX_PATTERN];
  logic [7:0]             eff    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match;
  logic [MAX_PATTERN-1:0] lane_ok;

  // cells, each fed by the effective byte of its right neighbor; the last cell takes the new byte
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic       tail;
    logic [7:0] nb;
    assign tail = (count == WIN_W'(i));
    if (i == MAX_PATTERN - 1) begin : g_last
      assign nb = ctl.new_byte;
    end else begin : g_mid
      assign nb = eff[i+1];
    end
    sfr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .tail_sel (tail),
      .next_eff (nb),
      .pat_byte (pattern[8*i +: 8]),
      .stored_o (stored[i]),
      .eff_o    (eff[i]),
      .match_o  (match[i])
    );
    // lanes past the pattern length always agree
    assign lane_ok[i] = match[i] | (LEN_W'(i) >= plen);
    // pending bytes followed by a newline at the tail
    assign flush_bytes[8*i +: 8] = tail ? NEWLINE_BYTE : stored[i];
  end

  assign hit  = &lane_ok;
  assign head = eff[0];

endmodule
`default_nettype wire

// ===== src/sfr_out_queue.sv =====
// burst queue and byte serializer in front of the result channel
`default_nettype none
module sfr_out_queue import sfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire burst_t     push_burst,
  output logic            full,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_last,
  input  wire logic       out_stall
);

  burst_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r, fill_nxt;
  logic [63:0]         cur_bytes_r, cur_bytes_nxt;
  logic [BURST_W-1:0]  cur_rem_r, cur_rem_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic                take;
  logic                pop;

  assign full      = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign out_valid = cur_valid_r;
  assign out_byte  = cur_bytes_r[7:0];
  assign out_last  = (cur_rem_r == '0);

  // word leaves the serializer; refill once the burst is done
  assign take = cur_valid_r & ~out_stall;
  assign pop  = (fill_r != '0) & (~cur_valid_r | (take & out_last));

  always_comb begin
    wr_ptr_nxt    = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt    = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt      = fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    cur_bytes_nxt = cur_bytes_r;
    cur_rem_nxt   = cur_rem_r;
    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      cur_bytes_nxt = mem_r[rd_ptr_r].bytes;
      cur_rem_nxt   = mem_r[rd_ptr_r].len_m1;
      cur_valid_nxt = 1'b1;
    end else if (take) begin
      if (out_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        cur_bytes_nxt = {8'd0, cur_bytes_r[63:8]};
        cur_rem_nxt   = cur_rem_r - BURST_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_burst;
    end
  end

  // serializer payload
  always_ff @(posedge clk) begin
    cur_bytes_r <= cur_bytes_nxt;
    cur_rem_r   <= cur_rem_nxt;
  end

  // pointers and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      cur_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfr_checker.sv =====
// port-level checks for the find-and-replace top, bound to it
`default_nettype none
module sfr_checker import sfr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_req_type,
  input wire logic [7:0]  in_data_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        out_last_of_run
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("result word changed under stall");

  // reset empties the serializer
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the queue, so input is open
  a_reset_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // a newline taken while no result is shown produces output once it has passed the queue and the serializer register
  a_newline_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type && in_data_byte == NEWLINE_BYTE && !out_valid
    |=> ##1 out_valid)
    else $error("newline produced no output");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);
`default_nettype wire
